[hdl/hse_pkg.sv]
`default_nettype none
package hse_pkg;

  // default geometry
  localparam int unsigned VOXELS_DEF   = 64;
  localparam int unsigned MAX_BINS_DEF = 1024;

  // fixed field widths
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned VOX_W     = 6;
  localparam int unsigned VAL_W     = 24;
  localparam int unsigned DROP_W    = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned BIN_OUT_W = 11;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned RNG_W     = VAL_W + 1;
  localparam int unsigned DEN_W     = RNG_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // item selectors
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEAK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MED   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOWC  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UPC   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_HPD   = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BINS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC = 2'd3;

  // register reset values
  localparam logic [10:0]       BINS_RST = 11'd1000;
  localparam logic [VAL_W-1:0]  LOW_RST  = 24'd8192;
  localparam logic [VAL_W-1:0]  HIGH_RST = 24'd16384;
  localparam logic [FRAC_W-1:0] FRAC_RST = 16'd62259;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_VMOD, S_DISP,
    S_MUL, S_DIVI, S_DIVR, S_DIVF,
    S_ADD_DV, S_ADD_RD, S_ADD_WR,
    S_CTR, S_CTR_DONE, S_CLR,
    S_PK_CHK, S_PK_USE,
    S_MD_CHK, S_MD_USI, S_MD_USJ,
    S_LC_CHK, S_LC_USE, S_UC_CHK, S_UC_USE,
    S_HS_CHK, S_HS_USE, S_HN1, S_HN2, S_HN3,
    S_HI_CHK, S_HI_USE, S_HJ_CHK, S_HJ_USE,
    S_HE_L, S_HE_R, S_HCMP, S_FIN
  } state_e;

  // clamp to the signed 24-bit range
  function automatic logic [VAL_W-1:0] sat24(input logic signed [63:0] x);
    logic [VAL_W-1:0] r;
    if (x > 64'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (x < -64'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/hse_ram.sv]
`default_nettype none
module hse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/histogram_statistics_engine_core.sv]
`default_nettype none
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   mode_i voxel_i sample_value_i drop_count_i
// out      out_valid_o / out_stall_i bin_index_o value_a_o value_b_o value_c_o found_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// One item at a time; one shared multiplier and a bit-serial divider (one quotient
// bit per cycle) under a sequencer, histogram counts in a single RAM.
// Add: two divides plus a read-modify-write of the RAM.
// Peak, median, credible: a RAM read per bin visited, plus one divide for the centre (peak: only if found).
// HPD: O(B*B) RAM reads, two divides per qualifying window. Clear: a write to each of MAX_BINS words.
// After reset a clearing pass over all VOXELS*MAX_BINS words runs with in_stall_o high.
module histogram_statistics_engine_core import hse_pkg::*; #(
  parameter int unsigned VOXELS   = VOXELS_DEF,
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [MODE_W-1:0]       mode_i,
  input  wire logic [VOX_W-1:0]        voxel_i,
  input  wire logic signed [VAL_W-1:0] sample_value_i,
  input  wire logic [DROP_W-1:0]       drop_count_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [BIN_OUT_W-1:0]         bin_index_o,
  output logic signed [VAL_W-1:0]      value_a_o,
  output logic signed [VAL_W-1:0]      value_b_o,
  output logic signed [VAL_W-1:0]      value_c_o,
  output logic                         found_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]    cfg_data_i
);
  localparam int unsigned DEPTH = VOXELS * MAX_BINS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned BW    = $clog2(MAX_BINS + 1);
  localparam int unsigned MA_W  = BW + 2;
  localparam int unsigned PW    = MA_W + RNG_W;
  localparam int unsigned XW    = PW + 2;
  localparam int unsigned CW    = CNT_W + BW + 1;
  localparam int unsigned HALF  = CW / 2;
  localparam int unsigned PT_W  = CW + FRAC_W;
  localparam int unsigned DC_W  = $clog2(PW);

  state_e state_q, state_d, ret_q, ret_d;

  // configuration
  logic [10:0]              bins_q;
  logic signed [VAL_W-1:0]  low_q, high_q;
  logic [FRAC_W-1:0]        frac_q;

  // item and working registers
  logic [MODE_W-1:0]        mode_q, mode_d;
  logic [VOX_W-1:0]         vox_q, vox_d;
  logic signed [VAL_W-1:0]  smp_q, smp_d;
  logic [DROP_W-1:0]        drop_q, drop_d;
  logic [BW-1:0]            i_q, i_d, j_q, j_d, bin_q, bin_d;
  logic [CW-1:0]            ci_q, ci_d, cj_q, cj_d, need_q, need_d;
  logic [CNT_W-1:0]         m_q, m_d;
  logic                     found_q, found_d;
  logic signed [XW-1:0]     va_q, va_d, vb_q, vb_d, ml_q, ml_d, mr_q, mr_d;
  logic signed [XW-1:0]     l_q, l_d, r_q, r_d;
  logic signed [XW:0]       vc_q, vc_d, mw_q, mw_d;
  logic [HALF+FRAC_W-1:0]   plo_q, plo_d;
  logic [CW-HALF+FRAC_W-1:0] phi_q, phi_d;
  logic [AW-1:0]            init_q, init_d;

  // shared multiply / divide unit
  logic [MA_W-1:0]          mul_a_q, mul_a_d;
  logic signed [RNG_W-1:0]  mul_b_q, mul_b_d;
  logic [DEN_W-1:0]         den_q, den_d;
  logic signed [PW-1:0]     prod_q, prod_d;
  logic                     sign_q, sign_d;
  logic [PW-1:0]            dnum_q, dnum_d;
  logic [DEN_W-1:0]         rem_q, rem_d;
  logic [DC_W-1:0]          dcnt_q, dcnt_d;
  logic signed [PW:0]       res_q, res_d;

  // output register
  logic                     out_valid_q, out_load;
  logic [BIN_OUT_W-1:0]     obin_q;
  logic [VAL_W-1:0]         ova_q, ovb_q, ovc_q;
  logic                     ofound_q;

  // memory port
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [CNT_W-1:0]         ram_wdata, ram_rdata;

  // derived values
  logic [BW-1:0]            nb, nb_m1;
  logic signed [RNG_W-1:0]  rng;
  logic signed [XW-1:0]     low_x;
  logic [31:0]              vox_base;
  logic [DEN_W:0]           rem_sh;
  logic                     div_ge;
  logic [PT_W-1:0]          psum;
  logic signed [XW:0]       win_w;

  function automatic logic [AW-1:0] maddr(input logic [31:0] base, input logic [BW-1:0] idx);
    return AW'(base + 32'(idx));
  endfunction

  always_comb begin
    if (bins_q == 11'd0) begin
      nb = BW'(1);
    end else if (32'(bins_q) > 32'(MAX_BINS)) begin
      nb = BW'(MAX_BINS);
    end else begin
      nb = BW'(bins_q);
    end
  end
  assign nb_m1    = nb - BW'(1);
  assign rng      = RNG_W'(high_q) - RNG_W'(low_q);
  assign low_x    = XW'(low_q);
  assign vox_base = 32'(vox_q) * 32'(MAX_BINS);
  assign rem_sh   = {rem_q, dnum_q[PW-1]};
  assign div_ge   = rem_sh >= {1'b0, den_q};
  assign psum     = (PT_W'(phi_q) << HALF) + PT_W'(plo_q);
  assign win_w    = (XW + 1)'(r_q) - (XW + 1)'(l_q);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_RST;
      low_q  <= LOW_RST;
      high_q <= HIGH_RST;
      frac_q <= FRAC_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BINS: bins_q <= cfg_data_i[10:0];
        REG_LOW:  low_q  <= cfg_data_i[VAL_W-1:0];
        REG_HIGH: high_q <= cfg_data_i[VAL_W-1:0];
        REG_FRAC: frac_q <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ret_q       <= S_IDLE;
      init_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      init_q  <= init_d;
      dcnt_q  <= dcnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;  vox_q <= vox_d;   smp_q <= smp_d;   drop_q <= drop_d;
    i_q    <= i_d;     j_q   <= j_d;     bin_q <= bin_d;
    ci_q   <= ci_d;    cj_q  <= cj_d;    need_q <= need_d; m_q <= m_d;
    found_q <= found_d;
    va_q <= va_d;  vb_q <= vb_d;  vc_q <= vc_d;
    ml_q <= ml_d;  mr_q <= mr_d;  mw_q <= mw_d;  l_q <= l_d;  r_q <= r_d;
    plo_q <= plo_d;  phi_q <= phi_d;
    mul_a_q <= mul_a_d;  mul_b_q <= mul_b_d;  den_q <= den_d;
    prod_q <= prod_d;  sign_q <= sign_d;  dnum_q <= dnum_d;  rem_q <= rem_d;
    res_q <= res_d;
    if (out_load) begin
      obin_q   <= BIN_OUT_W'(bin_q);
      ova_q    <= sat24(64'(va_q));
      ovb_q    <= sat24(64'(vb_q));
      ovc_q    <= sat24(64'(vc_q));
      ofound_q <= found_q;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  init_d = init_q;  dcnt_d = dcnt_q;
    mode_d = mode_q;  vox_d = vox_q;  smp_d = smp_q;  drop_d = drop_q;
    i_d = i_q;  j_d = j_q;  bin_d = bin_q;
    ci_d = ci_q;  cj_d = cj_q;  need_d = need_q;  m_d = m_q;  found_d = found_q;
    va_d = va_q;  vb_d = vb_q;  vc_d = vc_q;
    ml_d = ml_q;  mr_d = mr_q;  mw_d = mw_q;  l_d = l_q;  r_d = r_q;
    plo_d = plo_q;  phi_d = phi_q;
    mul_a_d = mul_a_q;  mul_b_d = mul_b_q;  den_d = den_q;
    prod_d = prod_q;  sign_d = sign_q;  dnum_d = dnum_q;  rem_d = rem_q;
    res_d = res_q;
    ram_we = 1'b0;  ram_waddr = '0;  ram_wdata = '0;  ram_raddr = '0;
    out_load = 1'b0;

    case (state_q)
      // zero the whole count memory after reset
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
        if (init_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          init_d = init_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          vox_d   = voxel_i;
          smp_d   = sample_value_i;
          drop_d  = drop_count_i;
          state_d = S_VMOD;
        end
      end

      // voxel modulo by repeated subtraction
      S_VMOD: begin
        if (32'(vox_q) >= 32'(VOXELS)) begin
          vox_d = vox_q - VOX_W'(VOXELS);
        end else begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        bin_d = '0;  va_d = '0;  vb_d = '0;  vc_d = '0;  found_d = 1'b1;
        i_d = '0;  ci_d = '0;  cj_d = '0;  m_d = '0;
        case (mode_q)
          MODE_ADD: begin
            if (rng > 0 && smp_q > low_q) begin
              mul_a_d = MA_W'(nb);
              mul_b_d = RNG_W'(smp_q) - RNG_W'(low_q);
              den_d   = $unsigned(rng);
              ret_d   = S_ADD_DV;
              state_d = S_MUL;
            end else begin
              state_d = S_ADD_RD;
            end
          end
          MODE_CLEAR: state_d = S_CLR;
          MODE_PEAK: begin
            found_d = 1'b0;
            state_d = S_PK_CHK;
          end
          MODE_MED: begin
            j_d     = nb_m1;
            state_d = S_MD_CHK;
          end
          MODE_LOWC: state_d = S_LC_CHK;
          MODE_UPC: begin
            i_d     = nb_m1;
            state_d = S_UC_CHK;
          end
          MODE_HPD: state_d = S_HS_CHK;
          default: begin
            found_d = 1'b0;
            state_d = S_FIN;
          end
        endcase
      end

      // shared unit: product, then signed floor division by den_q
      S_MUL: begin
        prod_d  = PW'($signed({1'b0, mul_a_q})) * PW'(mul_b_q);
        state_d = S_DIVI;
      end
      S_DIVI: begin
        sign_d  = prod_q[PW-1];
        dnum_d  = prod_q[PW-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = S_DIVR;
      end
      S_DIVR: begin
        rem_d  = div_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
        dnum_d = {dnum_q[PW-2:0], div_ge};
        dcnt_d = dcnt_q + DC_W'(1);
        if (dcnt_q == DC_W'(PW - 1)) begin
          state_d = S_DIVF;
        end
      end
      S_DIVF: begin
        if (sign_q) begin
          res_d = -$signed({1'b0, dnum_q}) - $signed({{PW{1'b0}}, rem_q != '0});
        end else begin
          res_d = $signed({1'b0, dnum_q});
        end
        state_d = ret_q;
      end

      // add: clamp bin, increment with saturation
      S_ADD_DV: begin
        if (res_q > $signed({1'b0, PW'(nb_m1)})) begin
          bin_d = nb_m1;
        end else begin
          bin_d = res_q[BW-1:0];
        end
        state_d = S_ADD_RD;
      end
      S_ADD_RD: begin
        ram_raddr = maddr(vox_base, bin_q);
        state_d   = S_ADD_WR;
      end
      S_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = maddr(vox_base, bin_q);
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + CNT_W'(1);
        state_d   = S_CTR;
      end

      // bin centre of bin_q
      S_CTR: begin
        mul_a_d = MA_W'({bin_q, 1'b1});
        mul_b_d = rng;
        den_d   = DEN_W'({nb, 1'b0});
        ret_d   = S_CTR_DONE;
        state_d = S_MUL;
      end
      S_CTR_DONE: begin
        va_d    = low_x + XW'(res_q);
        state_d = S_FIN;
      end

      // clear one voxel row
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = maddr(vox_base, i_q);
        if (32'(i_q) == 32'(MAX_BINS - 1)) begin
          state_d = S_FIN;
        end else begin
          i_d = i_q + BW'(1);
        end
      end

      // peak scan
      S_PK_CHK: begin
        if (i_q < nb) begin
          ram_raddr = maddr(vox_base, i_q);
          state_d   = S_PK_USE;
        end else begin
          state_d = found_q ? S_CTR : S_FIN;
        end
      end
      S_PK_USE: begin
        if (ram_rdata > m_q) begin
          m_d     = ram_rdata;
          bin_d   = i_q;
          found_d = 1'b1;
        end
        i_d     = i_q + BW'(1);
        state_d = S_PK_CHK;
      end

      // two-pointer median
      S_MD_CHK: begin
        if (i_q != j_q) begin
          if (ci_q < cj_q) begin
            ram_raddr = maddr(vox_base, i_q);
            state_d   = S_MD_USI;
          end else begin
            ram_raddr = maddr(vox_base, j_q);
            state_d   = S_MD_USJ;
          end
        end else begin
          bin_d   = i_q;
          state_d = S_CTR;
        end
      end
      S_MD_USI: begin
        ci_d    = ci_q + CW'(ram_rdata);
        i_d     = i_q + BW'(1);
        state_d = S_MD_CHK;
      end
      S_MD_USJ: begin
        cj_d    = cj_q + CW'(ram_rdata);
        j_d     = j_q - BW'(1);
        state_d = S_MD_CHK;
      end

      // lower credible bin
      S_LC_CHK: begin
        if (i_q < nb && ci_q < CW'(drop_q)) begin
          ram_raddr = maddr(vox_base, i_q);
          state_d   = S_LC_USE;
        end else begin
          bin_d   = i_q;
          state_d = S_CTR;
        end
      end
      S_LC_USE: begin
        if (CW'(ram_rdata) + ci_q >= CW'(drop_q)) begin
          bin_d   = i_q;
          state_d = S_CTR;
        end else begin
          ci_d    = ci_q + CW'(ram_rdata);
          i_d     = i_q + BW'(1);
          state_d = S_LC_CHK;
        end
      end

      // upper credible bin
      S_UC_CHK: begin
        if (i_q != '0 && ci_q < CW'(drop_q)) begin
          ram_raddr = maddr(vox_base, i_q);
          state_d   = S_UC_USE;
        end else begin
          bin_d   = i_q;
          state_d = S_CTR;
        end
      end
      S_UC_USE: begin
        if (CW'(ram_rdata) + ci_q >= CW'(drop_q)) begin
          bin_d   = i_q;
          state_d = S_CTR;
        end else begin
          ci_d    = ci_q + CW'(ram_rdata);
          i_d     = i_q - BW'(1);
          state_d = S_UC_CHK;
        end
      end

      // hpd: total count
      S_HS_CHK: begin
        if (i_q < nb) begin
          ram_raddr = maddr(vox_base, i_q);
          state_d   = S_HS_USE;
        end else begin
          state_d = S_HN1;
        end
      end
      S_HS_USE: begin
        ci_d    = ci_q + CW'(ram_rdata);
        i_d     = i_q + BW'(1);
        state_d = S_HS_CHK;
      end

      // hpd: needed mass, two partial products
      S_HN1: begin
        plo_d   = (HALF + FRAC_W)'(ci_q[HALF-1:0]) * (HALF + FRAC_W)'(frac_q);
        state_d = S_HN2;
      end
      S_HN2: begin
        phi_d   = (CW - HALF + FRAC_W)'(ci_q[CW-1:HALF]) * (CW - HALF + FRAC_W)'(frac_q);
        state_d = S_HN3;
      end
      S_HN3: begin
        need_d  = CW'(psum >> FRAC_W);
        found_d = 1'b0;
        mw_d    = (XW + 1)'(rng);
        ml_d    = low_x;
        mr_d    = XW'(high_q);
        bin_d   = '0;
        i_d     = '0;
        state_d = S_HI_CHK;
      end

      // hpd: window starting at bin i
      S_HI_CHK: begin
        if (i_q < nb) begin
          ram_raddr = maddr(vox_base, i_q);
          state_d   = S_HI_USE;
        end else begin
          va_d    = ml_q;
          vb_d    = mr_q;
          vc_d    = mw_q;
          state_d = S_FIN;
        end
      end
      S_HI_USE: begin
        ci_d    = CW'(ram_rdata);
        j_d     = i_q + BW'(1);
        state_d = S_HJ_CHK;
      end
      S_HJ_CHK: begin
        if (j_q < nb && ci_q < need_q) begin
          ram_raddr = maddr(vox_base, j_q);
          state_d   = S_HJ_USE;
        end else if (ci_q >= need_q) begin
          mul_a_d = MA_W'(i_q);
          mul_b_d = rng;
          den_d   = DEN_W'(nb);
          ret_d   = S_HE_L;
          state_d = S_MUL;
        end else begin
          i_d     = i_q + BW'(1);
          state_d = S_HI_CHK;
        end
      end
      S_HJ_USE: begin
        ci_d    = ci_q + CW'(ram_rdata);
        j_d     = j_q + BW'(1);
        state_d = S_HJ_CHK;
      end
      S_HE_L: begin
        l_d     = low_x + XW'(res_q);
        mul_a_d = MA_W'(j_q);
        ret_d   = S_HE_R;
        state_d = S_MUL;
      end
      S_HE_R: begin
        r_d     = low_x + XW'(res_q);
        state_d = S_HCMP;
      end
      S_HCMP: begin
        found_d = 1'b1;
        if (win_w < mw_q) begin
          mw_d  = win_w;
          ml_d  = l_q;
          mr_d  = r_q;
          bin_d = i_q;
        end
        i_d     = i_q + BW'(1);
        state_d = S_HI_CHK;
      end

      // hand result to the output register
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  hse_ram #(
    .WIDTH(CNT_W),
    .DEPTH(DEPTH)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign bin_index_o = obin_q;
  assign value_a_o   = ova_q;
  assign value_b_o   = ovb_q;
  assign value_c_o   = ovc_q;
  assign found_o     = ofound_q;

  // counts are written only by the init pass, an add or a clear
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INIT || state_q == S_ADD_WR || state_q == S_CLR))
    else $error("count memory written outside add, clear or init");

  // a new result appears only from the finish step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside finish");

  // finish with a free output register returns to idle with a valid result in the next cycle
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && !out_valid_q) |=> (state_q == S_IDLE && out_valid_q))
    else $error("finish stalled with a free output register");

  // divider always exits after PW steps
  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVR && dcnt_q == DC_W'(PW - 1)) |=> (state_q == S_DIVF))
    else $error("divider did not finish");

endmodule
`default_nettype wire
